### hdl/v3a_pkg.sv
`timescale 1ns / 1ps
// v3a_pkg: shared types, codes and constants of the three-component vector unit.
// No dependencies; used by every module of the block.
package v3a_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int OP_W          = 4;
	localparam int MINLEN_W      = 17;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;
	localparam int QUEUE_DEPTH   = 4;
	localparam int SQ_W          = 64;

	localparam logic [MINLEN_W-1:0] MINLEN_RST = 17'd1;

	// register index, taken from paddr[2]
	localparam logic REG_MIN_LENGTH = 1'b0;

	// opcodes
	localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
	localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
	localparam logic [OP_W-1:0] OP_MUL   = 4'd2;
	localparam logic [OP_W-1:0] OP_SCALE = 4'd3;
	localparam logic [OP_W-1:0] OP_DOT   = 4'd4;
	localparam logic [OP_W-1:0] OP_CROSS = 4'd5;
	localparam logic [OP_W-1:0] OP_LEN   = 4'd6;
	localparam logic [OP_W-1:0] OP_NORM  = 4'd7;
	localparam logic [OP_W-1:0] OP_RAY   = 4'd8;

	// operation class decided in the front end
	typedef enum logic [3:0] {
		CL_NONE,
		CL_ADD,
		CL_SUB,
		CL_MUL,
		CL_SCALE,
		CL_DOT,
		CL_CROSS,
		CL_LEN,
		CL_NORM,
		CL_RAY
	} op_class_t;

	// one queued word
	typedef struct packed {
		op_class_t                    cls;
		logic [2:0][DATA_W-1:0]       a;
		logic [2:0][DATA_W-1:0]       b;
		logic [DATA_W-1:0]            s;
	} item_t;

	// one result word
	typedef struct packed {
		logic [2:0][DATA_W-1:0]       r;
		logic [DATA_W-1:0]            sc;
		logic                         ovf;
	} res_t;

	// request into the root / divide unit
	typedef struct packed {
		logic                         start;
		logic                         norm;
		logic [SQ_W-1:0]              sq;
		logic [2:0][DATA_W-1:0]       a;
	} iter_req_t;

	// status of the root / divide unit
	typedef struct packed {
		logic                         idle;
		logic                         done;
	} iter_sts_t;

endpackage

### hdl/v3a_front.sv
`timescale 1ns / 1ps
// v3a_front: input handshake, opcode classification and the word queue.
// Depends on v3a_pkg.
module v3a_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [v3a_pkg::OP_W-1:0]          opcode,
	input  logic signed [v3a_pkg::DATA_W-1:0] a_x,
	input  logic signed [v3a_pkg::DATA_W-1:0] a_y,
	input  logic signed [v3a_pkg::DATA_W-1:0] a_z,
	input  logic signed [v3a_pkg::DATA_W-1:0] b_x,
	input  logic signed [v3a_pkg::DATA_W-1:0] b_y,
	input  logic signed [v3a_pkg::DATA_W-1:0] b_z,
	input  logic signed [v3a_pkg::DATA_W-1:0] scale_value,
	output logic                              q_valid,
	input  logic                              q_ready,
	output v3a_pkg::item_t                    q_item
);

	localparam int PW = $clog2(v3a_pkg::QUEUE_DEPTH);

	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;
	v3a_pkg::item_t  mem_q [v3a_pkg::QUEUE_DEPTH];
	v3a_pkg::item_t  new_item;
	logic            push;
	logic            pop;

	// classify the opcode
	always_comb begin
		case (opcode)
			v3a_pkg::OP_ADD:   new_item.cls = v3a_pkg::CL_ADD;
			v3a_pkg::OP_SUB:   new_item.cls = v3a_pkg::CL_SUB;
			v3a_pkg::OP_MUL:   new_item.cls = v3a_pkg::CL_MUL;
			v3a_pkg::OP_SCALE: new_item.cls = v3a_pkg::CL_SCALE;
			v3a_pkg::OP_DOT:   new_item.cls = v3a_pkg::CL_DOT;
			v3a_pkg::OP_CROSS: new_item.cls = v3a_pkg::CL_CROSS;
			v3a_pkg::OP_LEN:   new_item.cls = v3a_pkg::CL_LEN;
			v3a_pkg::OP_NORM:  new_item.cls = v3a_pkg::CL_NORM;
			v3a_pkg::OP_RAY:   new_item.cls = v3a_pkg::CL_RAY;
			default:           new_item.cls = v3a_pkg::CL_NONE;
		endcase
		new_item.a[0] = a_x;
		new_item.a[1] = a_y;
		new_item.a[2] = a_z;
		new_item.b[0] = b_x;
		new_item.b[1] = b_y;
		new_item.b[2] = b_z;
		new_item.s    = scale_value;
	end

	assign item_ready = (count_q != (PW+1)'(v3a_pkg::QUEUE_DEPTH));
	assign q_valid    = (count_q != '0);
	assign q_item     = mem_q[rd_ptr_q];
	assign push       = item_valid && item_ready;
	assign pop        = q_valid && q_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

### hdl/v3a_iter.sv
`timescale 1ns / 1ps
// v3a_iter: iterative square root (one root bit a cycle) and restoring divide
// (one quotient bit a cycle, three lanes) for length and normalize. Depends on v3a_pkg.
module v3a_iter #(
	parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  v3a_pkg::iter_req_t            req,
	input  logic [v3a_pkg::MINLEN_W-1:0]  min_length,
	input  logic                          take,
	output v3a_pkg::iter_sts_t            sts,
	output v3a_pkg::res_t                 res
);

	localparam int ROOT_STEPS = v3a_pkg::SQ_W / 2;
	localparam int RW   = ROOT_STEPS;
	localparam int REMW = RW + 3;
	localparam int LW   = RW + 1;
	localparam int NUMW = LW + FRAC_BITS;
	localparam int QW   = FRAC_BITS + 1;
	localparam int CW   = $clog2((QW > ROOT_STEPS) ? QW : ROOT_STEPS);
	localparam logic [LW-1:0] LEN_MAX = LW'(32'h7FFF_FFFF);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_LEN,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   cnt_q;
	logic [v3a_pkg::SQ_W-1:0]        rad_q;
	logic [REMW-1:0]                 rem_q;
	logic [RW-1:0]                   root_q;
	logic                            norm_q;
	logic [2:0][v3a_pkg::DATA_W-1:0] a_q;
	logic [NUMW-1:0]                 dsh_q;
	logic [NUMW-1:0]                 drem_q [3];
	logic [QW-1:0]                   quo_q [3];
	v3a_pkg::res_t                   res_q;

	logic [REMW-1:0]                 rem_pre;
	logic [REMW-1:0]                 trial;
	logic [LW-1:0]                   len;
	logic [v3a_pkg::DATA_W-1:0]      mag [3];

	// one root step and the rounded length
	always_comb begin
		rem_pre = {rem_q[REMW-3:0], rad_q[v3a_pkg::SQ_W-1 -: 2]};
		trial   = REMW'({root_q, 2'b01});
		len     = LW'(root_q) + LW'(rem_q > REMW'(root_q));
		for (int i = 0; i < 3; i++) begin
			mag[i] = a_q[i][v3a_pkg::DATA_W-1] ? (~a_q[i] + 1'b1) : a_q[i];
		end
	end

	assign sts.idle = (state_q == ST_IDLE);
	assign sts.done = (state_q == ST_DONE);
	assign res      = res_q;

	// sequencer with its datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rad_q   <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			norm_q  <= 1'b0;
			a_q     <= '0;
			dsh_q   <= '0;
			res_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				drem_q[i] <= '0;
				quo_q[i]  <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						rad_q   <= req.sq;
						norm_q  <= req.norm;
						a_q     <= req.a;
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= CW'(ROOT_STEPS - 1);
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					rad_q <= rad_q << 2;
					if (rem_pre >= trial) begin
						rem_q  <= rem_pre - trial;
						root_q <= {root_q[RW-2:0], 1'b1};
					end else begin
						rem_q  <= rem_pre;
						root_q <= {root_q[RW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					res_q.r <= '0;
					if (!norm_q) begin
						// length: saturate to the signed range
						if (len > LEN_MAX) begin
							res_q.sc  <= 32'h7FFF_FFFF;
							res_q.ovf <= 1'b1;
						end else begin
							res_q.sc  <= len[v3a_pkg::DATA_W-1:0];
							res_q.ovf <= 1'b0;
						end
						state_q <= ST_DONE;
					end else begin
						res_q.sc  <= '0;
						res_q.ovf <= 1'b0;
						if (len == '0 || len < LW'(min_length)) begin
							// too short to normalize: zero vector
							state_q <= ST_DONE;
						end else begin
							dsh_q <= NUMW'(len) << FRAC_BITS;
							for (int i = 0; i < 3; i++) begin
								drem_q[i] <= (NUMW'(mag[i]) << FRAC_BITS) + NUMW'(len >> 1);
								quo_q[i]  <= '0;
							end
							cnt_q   <= CW'(QW - 1);
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					for (int i = 0; i < 3; i++) begin
						if (drem_q[i] >= dsh_q) begin
							drem_q[i] <= drem_q[i] - dsh_q;
							quo_q[i]  <= {quo_q[i][QW-2:0], 1'b1};
						end else begin
							quo_q[i]  <= {quo_q[i][QW-2:0], 1'b0};
						end
					end
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// quotient never exceeds one in fixed point, so no saturation
					for (int i = 0; i < 3; i++) begin
						res_q.r[i] <= a_q[i][v3a_pkg::DATA_W-1] ?
							(~v3a_pkg::DATA_W'(quo_q[i]) + 1'b1) : v3a_pkg::DATA_W'(quo_q[i]);
					end
					res_q.sc  <= '0;
					res_q.ovf <= 1'b0;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/v3a_back.sv
`timescale 1ns / 1ps
// v3a_back: multiplier stage, round and saturate, output register and the
// hand-off to the root / divide unit. Depends on v3a_pkg and v3a_iter.
module v3a_back #(
	parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  v3a_pkg::item_t                    q_item,
	input  logic [v3a_pkg::MINLEN_W-1:0]      min_length,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic signed [v3a_pkg::DATA_W-1:0] r_x,
	output logic signed [v3a_pkg::DATA_W-1:0] r_y,
	output logic signed [v3a_pkg::DATA_W-1:0] r_z,
	output logic signed [v3a_pkg::DATA_W-1:0] r_scalar,
	output logic                              overflow
);

	localparam int DW   = v3a_pkg::DATA_W;
	localparam int PRW  = 2 * DW;
	localparam int SUMW = PRW + 2;
	localparam logic signed [SUMW-1:0] HALF = SUMW'(1) << (FRAC_BITS - 1);
	localparam logic signed [SUMW-1:0] MAXV = SUMW'(32'h7FFF_FFFF);
	localparam logic signed [SUMW-1:0] MINV = -SUMW'(33'h0_8000_0000);

	// operand select for the multiplier lanes
	logic signed [DW-1:0]  m1x [3];
	logic signed [DW-1:0]  m1y [3];
	logic signed [DW-1:0]  m2x [3];
	logic signed [DW-1:0]  m2y [3];

	// stage 1 registers
	logic                  valid_s1;
	v3a_pkg::op_class_t    cls_s1;
	logic signed [PRW-1:0] p1_s1 [3];
	logic signed [PRW-1:0] p2_s1 [3];
	logic signed [DW-1:0]  a_s1 [3];
	logic signed [DW-1:0]  b_s1 [3];

	// output register
	logic                  result_valid_q;
	v3a_pkg::res_t         out_q;

	v3a_pkg::res_t         res_fast;
	v3a_pkg::res_t         res_iter;
	v3a_pkg::iter_req_t    req;
	v3a_pkg::iter_sts_t    sts;

	logic                  s1_fast;
	logic                  out_free;
	logic                  load_iter;
	logic                  load_s1;
	logic                  s1_leave;
	logic                  take_q;

	// saturate to 32 bits; top bit is the overflow flag
	function automatic logic [DW:0] sat32(input logic signed [SUMW-1:0] v);
		logic [DW:0] r;
		if (v > MAXV) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < MINV) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[DW-1:0]};
		end
		return r;
	endfunction

	// round to nearest, ties up, then saturate
	function automatic logic [DW:0] rnd_sat(input logic signed [SUMW-1:0] v);
		logic signed [SUMW-1:0] t;
		t = (v + HALF) >>> FRAC_BITS;
		return sat32(t);
	endfunction

	// pick multiplier operands
	always_comb begin
		int j;
		int k;
		for (int i = 0; i < 3; i++) begin
			j = (i == 2) ? 0 : i + 1;
			k = (i == 0) ? 2 : i - 1;
			m1x[i] = '0;
			m1y[i] = '0;
			m2x[i] = '0;
			m2y[i] = '0;
			case (q_item.cls)
				v3a_pkg::CL_MUL, v3a_pkg::CL_DOT: begin
					m1x[i] = q_item.a[i];
					m1y[i] = q_item.b[i];
				end
				v3a_pkg::CL_SCALE: begin
					m1x[i] = q_item.a[i];
					m1y[i] = q_item.s;
				end
				v3a_pkg::CL_CROSS: begin
					m1x[i] = q_item.a[j];
					m1y[i] = q_item.b[k];
					m2x[i] = q_item.a[k];
					m2y[i] = q_item.b[j];
				end
				v3a_pkg::CL_RAY: begin
					m1x[i] = q_item.b[i];
					m1y[i] = q_item.s;
				end
				v3a_pkg::CL_LEN, v3a_pkg::CL_NORM: begin
					m1x[i] = q_item.a[i];
					m1y[i] = q_item.a[i];
				end
				default: begin
					m1x[i] = '0;
				end
			endcase
		end
	end

	// handshake between the stages
	assign s1_fast   = valid_s1 && (cls_s1 != v3a_pkg::CL_LEN) && (cls_s1 != v3a_pkg::CL_NORM);
	assign out_free  = !result_valid_q || result_ready;
	assign load_iter = sts.done && out_free;
	assign load_s1   = s1_fast && sts.idle && out_free;
	assign req.start = valid_s1 && !s1_fast && sts.idle;
	assign s1_leave  = load_s1 || req.start;
	assign q_ready   = !valid_s1 || s1_leave;
	assign take_q    = load_iter;

	// request to the root / divide unit
	always_comb begin
		req.norm = (cls_s1 == v3a_pkg::CL_NORM);
		req.sq   = v3a_pkg::SQ_W'(p1_s1[0]) + v3a_pkg::SQ_W'(p1_s1[1])
			+ v3a_pkg::SQ_W'(p1_s1[2]);
		for (int i = 0; i < 3; i++) begin
			req.a[i] = a_s1[i];
		end
	end

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (q_valid && q_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_leave) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			cls_s1 <= q_item.cls;
			for (int i = 0; i < 3; i++) begin
				p1_s1[i] <= PRW'(m1x[i]) * PRW'(m1y[i]);
				p2_s1[i] <= PRW'(m2x[i]) * PRW'(m2y[i]);
				a_s1[i]  <= q_item.a[i];
				b_s1[i]  <= q_item.b[i];
			end
		end
	end

	// combine, round and saturate
	always_comb begin
		logic signed [SUMW-1:0] w;
		logic [DW:0]            t;
		res_fast = '0;
		for (int i = 0; i < 3; i++) begin
			w = SUMW'(p1_s1[i]);
			if (cls_s1 == v3a_pkg::CL_CROSS) begin
				w = w - SUMW'(p2_s1[i]);
			end
			if (cls_s1 == v3a_pkg::CL_RAY) begin
				w = w + (SUMW'(a_s1[i]) <<< FRAC_BITS);
			end
			case (cls_s1)
				v3a_pkg::CL_ADD: t = sat32(SUMW'(a_s1[i]) + SUMW'(b_s1[i]));
				v3a_pkg::CL_SUB: t = sat32(SUMW'(a_s1[i]) - SUMW'(b_s1[i]));
				v3a_pkg::CL_MUL, v3a_pkg::CL_SCALE,
				v3a_pkg::CL_CROSS, v3a_pkg::CL_RAY: t = rnd_sat(w);
				default: t = '0;
			endcase
			res_fast.r[i] = t[DW-1:0];
			res_fast.ovf  = res_fast.ovf | t[DW];
		end
		if (cls_s1 == v3a_pkg::CL_DOT) begin
			t = rnd_sat(SUMW'(p1_s1[0]) + SUMW'(p1_s1[1]) + SUMW'(p1_s1[2]));
			res_fast.sc  = t[DW-1:0];
			res_fast.ovf = t[DW];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_iter || load_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_iter) begin
			out_q <= res_iter;
		end else if (load_s1) begin
			out_q <= res_fast;
		end
	end

	v3a_iter #(
		.FRAC_BITS (FRAC_BITS)
	) u_iter (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.min_length (min_length),
		.take       (take_q),
		.sts        (sts),
		.res        (res_iter)
	);

	assign result_valid = result_valid_q;
	assign r_x          = out_q.r[0];
	assign r_y          = out_q.r[1];
	assign r_z          = out_q.r[2];
	assign r_scalar     = out_q.sc;
	assign overflow     = out_q.ovf;

endmodule

### hdl/vector3_alu.sv
`timescale 1ns / 1ps
// vector3_alu: three-component Q16.16 vector unit, top level with the APB register.
// Throughput: one word per cycle for add, sub, mul, scale, dot, cross and ray point while
// the output register is free and the root/divide unit is idle; each such word passes the
// queue, the multiplier stage and the output register. Length and normalize use the shared
// root/divide unit one word at a time: the next starts once the last result is taken.
// Reset: asynchronous, active low; clears the queue and pipeline, min_length resets to 1.
module vector3_alu #(
	parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [v3a_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [v3a_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [v3a_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic [v3a_pkg::OP_W-1:0]              opcode,
	input  logic signed [v3a_pkg::DATA_W-1:0]     a_x,
	input  logic signed [v3a_pkg::DATA_W-1:0]     a_y,
	input  logic signed [v3a_pkg::DATA_W-1:0]     a_z,
	input  logic signed [v3a_pkg::DATA_W-1:0]     b_x,
	input  logic signed [v3a_pkg::DATA_W-1:0]     b_y,
	input  logic signed [v3a_pkg::DATA_W-1:0]     b_z,
	input  logic signed [v3a_pkg::DATA_W-1:0]     scale_value,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic signed [v3a_pkg::DATA_W-1:0]     r_x,
	output logic signed [v3a_pkg::DATA_W-1:0]     r_y,
	output logic signed [v3a_pkg::DATA_W-1:0]     r_z,
	output logic signed [v3a_pkg::DATA_W-1:0]     r_scalar,
	output logic                                  overflow
);

	logic [v3a_pkg::MINLEN_W-1:0] min_length_q;
	logic                         q_valid;
	logic                         q_ready;
	v3a_pkg::item_t               q_item;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= v3a_pkg::MINLEN_RST;
		end else if (psel && penable && pwrite && (paddr[2] == v3a_pkg::REG_MIN_LENGTH)) begin
			min_length_q <= pwdata[v3a_pkg::MINLEN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == v3a_pkg::REG_MIN_LENGTH) ?
		v3a_pkg::APB_DATA_W'(min_length_q) : '0;

	v3a_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.opcode      (opcode),
		.a_x         (a_x),
		.a_y         (a_y),
		.a_z         (a_z),
		.b_x         (b_x),
		.b_y         (b_y),
		.b_z         (b_z),
		.scale_value (scale_value),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_item      (q_item)
	);

	v3a_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_item       (q_item),
		.min_length   (min_length_q),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.r_x          (r_x),
		.r_y          (r_y),
		.r_z          (r_z),
		.r_scalar     (r_scalar),
		.overflow     (overflow)
	);

endmodule

### verif/vector3_alu_test.sv
`timescale 1ns / 1ps
// vector3_alu_test: self-checking bench for the Q16.16 vector unit, with an in-bench
// predictor, random idling on both channels and APB writes of min_length.
// Depends on hdl/v3a_pkg.sv and hdl/vector3_alu.sv.
module vector3_alu_test;

	localparam int DATA_W     = v3a_pkg::DATA_W;
	localparam int OP_W       = v3a_pkg::OP_W;
	localparam int MINLEN_W   = v3a_pkg::MINLEN_W;
	localparam int APB_ADDR_W = v3a_pkg::APB_ADDR_W;
	localparam int APB_DATA_W = v3a_pkg::APB_DATA_W;
	localparam int FB         = v3a_pkg::FRAC_BITS_DEF;
	localparam int STALL_MAX  = 5000;
	localparam int DRAIN_CYC  = 80;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] a[3];
		logic signed [DATA_W-1:0] b[3];
		logic signed [DATA_W-1:0] s;
	} vec_word_t;

	typedef struct {
		logic signed [DATA_W-1:0] v[3];
		logic signed [DATA_W-1:0] sc;
		logic                     ovf;
	} vec_res_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;
	logic item_valid, item_ready, result_valid, result_ready, overflow;
	logic [OP_W-1:0] opcode;
	logic signed [DATA_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z, scale_value;
	logic signed [DATA_W-1:0] r_x, r_y, r_z, r_scalar;

	vec_word_t word_queue[$];
	vec_res_t  result_queue[$];
	logic [MINLEN_W-1:0] min_len_q;
	int  mismatches;
	int  hold_ask, hold_seen;
	logic took;
	int  gap_left, rgap_left, hold_left, quiet;
	bit  apb_wr;

	vector3_alu u_top (.*);

	// clock
	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// saturate to 32 bits, flag overflow
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [95:0] v,
			inout logic ovf);
		if (v > 96'sd2147483647) begin
			ovf = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -96'sd2147483648) begin
			ovf = 1'b1;
			return 32'sh80000000;
		end
		return v[DATA_W-1:0];
	endfunction

	// round to nearest, ties up, dropping the fraction bits
	function automatic logic signed [95:0] rnd_frac(input logic signed [95:0] v);
		return (v + (96'sd1 <<< (FB - 1))) >>> FB;
	endfunction

	// root of a sum of squares, rounded to nearest
	function automatic logic [63:0] round_root(input logic [63:0] sq);
		logic [63:0]  root, t;
		logic [127:0] tt, rem;
		root = '0;
		for (int i = 31; i >= 0; i--) begin
			t  = root | (64'd1 << i);
			tt = t * t;
			if (tt <= {64'd0, sq})
				root = t;
		end
		tt  = root * root;
		rem = {64'd0, sq} - tt;
		if (rem > {64'd0, root})
			root = root + 64'd1;
		return root;
	endfunction

	function automatic vec_res_t vector_result(input vec_word_t w, input logic [MINLEN_W-1:0] ml);
		vec_res_t res;
		logic signed [95:0] acc;
		logic [63:0] sq, len, mag, q;
		int j, k;
		res.v[0] = '0; res.v[1] = '0; res.v[2] = '0;
		res.sc = '0;
		res.ovf = 1'b0;
		case (w.op)
			v3a_pkg::OP_ADD: for (int i = 0; i < 3; i++) begin
				acc = w.a[i];
				acc = acc + w.b[i];
				res.v[i] = sat32(acc, res.ovf);
			end
			v3a_pkg::OP_SUB: for (int i = 0; i < 3; i++) begin
				acc = w.a[i];
				acc = acc - w.b[i];
				res.v[i] = sat32(acc, res.ovf);
			end
			v3a_pkg::OP_MUL: for (int i = 0; i < 3; i++) begin
				acc = w.a[i] * w.b[i];
				res.v[i] = sat32(rnd_frac(acc), res.ovf);
			end
			v3a_pkg::OP_SCALE: for (int i = 0; i < 3; i++) begin
				acc = w.a[i] * w.s;
				res.v[i] = sat32(rnd_frac(acc), res.ovf);
			end
			v3a_pkg::OP_DOT: begin
				acc = w.a[0] * w.b[0] + w.a[1] * w.b[1] + w.a[2] * w.b[2];
				res.sc = sat32(rnd_frac(acc), res.ovf);
			end
			v3a_pkg::OP_CROSS: for (int i = 0; i < 3; i++) begin
				j = (i + 1) % 3;
				k = (i + 2) % 3;
				acc = w.a[j] * w.b[k] - w.a[k] * w.b[j];
				res.v[i] = sat32(rnd_frac(acc), res.ovf);
			end
			v3a_pkg::OP_LEN, v3a_pkg::OP_NORM: begin
				acc = w.a[0] * w.a[0] + w.a[1] * w.a[1] + w.a[2] * w.a[2];
				sq  = acc[63:0];
				len = round_root(sq);
				if (w.op == v3a_pkg::OP_LEN) begin
					acc = {32'd0, len};
					res.sc = sat32(acc, res.ovf);
				end else if (len != 0 && len >= {47'd0, ml}) begin
					for (int i = 0; i < 3; i++) begin
						acc = w.a[i];
						if (acc < 0)
							acc = -acc;
						mag = acc[63:0] << FB;
						q   = (mag + len / 2) / len;
						acc = {32'd0, q};
						if (w.a[i] < 0)
							acc = -acc;
						res.v[i] = sat32(acc, res.ovf);
					end
				end
			end
			v3a_pkg::OP_RAY: for (int i = 0; i < 3; i++) begin
				acc = w.a[i];
				acc = (acc <<< FB) + w.b[i] * w.s;
				res.v[i] = sat32(rnd_frac(acc), res.ovf);
			end
			default: ;
		endcase
		return res;
	endfunction

	// operand mix: extremes, small magnitudes, mid-size and full random
	function automatic logic signed [DATA_W-1:0] pick_val();
		case ($urandom_range(0, 9))
			0: return 32'sh80000000;
			1: return 32'sh7fffffff;
			2, 3, 4: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
			5, 6: return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_gap();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 0;
			5, 6, 7, 8: return $urandom_range(1, 3);
			default: return $urandom_range(10, 40);
		endcase
	endfunction

	task automatic push_word(input logic [OP_W-1:0] op,
			input logic signed [DATA_W-1:0] ax, ay, az, bx, by, bz, sv);
		vec_word_t w;
		w.op = op;
		w.a[0] = ax; w.a[1] = ay; w.a[2] = az;
		w.b[0] = bx; w.b[1] = by; w.b[2] = bz;
		w.s = sv;
		word_queue.push_back(w);
	endtask

	task automatic push_random(input int n);
		logic [OP_W-1:0] op;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(9, 15))
				: OP_W'($urandom_range(0, 8));
			push_word(op, pick_val(), pick_val(), pick_val(), pick_val(), pick_val(),
				pick_val(), pick_val());
		end
	endtask

	// wait for every word sent and every result back, then let the root unit settle
	task automatic wait_idle();
		while (word_queue.size() != 0 || result_queue.size() != 0 || item_valid)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_min_length(input logic [MINLEN_W-1:0] val);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {v3a_pkg::REG_MIN_LENGTH, 2'b00};
		pwdata  = {15'd0, val};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		min_len_q = val;
	endtask

	// stimulus phases
	initial begin
		logic [MINLEN_W-1:0] settings[4];
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		item_valid = 1'b0; result_ready = 1'b0;
		opcode = '0; a_x = '0; a_y = '0; a_z = '0; b_x = '0; b_y = '0; b_z = '0;
		scale_value = '0;
		min_len_q = v3a_pkg::MINLEN_RST;
		mismatches = 0;
		hold_ask = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, each op, rounding ties, saturation, normalize corners
		push_word(v3a_pkg::OP_ADD, 32'sh7fffffff, 32'sh80000000, 1, 1, -1, -1, 0);
		push_word(v3a_pkg::OP_SUB, 32'sh80000000, 32'sh7fffffff, 5, 1, -1, 7, 0);
		push_word(v3a_pkg::OP_MUL, 32'sh00018000, 32'sh80000000, 1, 32'sh00008000,
			32'sh80000000, 32'sh00008000, 0);
		push_word(v3a_pkg::OP_MUL, -1, 1, 3, 32'sh00008000, 32'sh00008000, 32'sh00008000, 0);
		push_word(v3a_pkg::OP_SCALE, 32'sh7fffffff, -32'sh10000, 32'sh00030000, 0, 0, 0,
			32'sh00020000);
		push_word(v3a_pkg::OP_SCALE, 1, -1, 3, 0, 0, 0, 32'sh00008000);
		push_word(v3a_pkg::OP_DOT, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
		push_word(v3a_pkg::OP_DOT, 32'sh10000, 32'sh20000, -32'sh30000, 32'sh10000,
			32'sh10000, 32'sh10000, 0);
		push_word(v3a_pkg::OP_CROSS, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 0);
		push_word(v3a_pkg::OP_CROSS, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
		push_word(v3a_pkg::OP_LEN, 32'sh30000, 32'sh40000, 0, 0, 0, 0, 0);
		push_word(v3a_pkg::OP_LEN, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0);
		push_word(v3a_pkg::OP_LEN, 0, 0, 0, 0, 0, 0, 0);
		push_word(v3a_pkg::OP_NORM, 0, 0, 0, 0, 0, 0, 0);
		push_word(v3a_pkg::OP_NORM, 32'sh30000, -32'sh40000, 0, 0, 0, 0, 0);
		push_word(v3a_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0);
		push_word(v3a_pkg::OP_NORM, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0);
		push_word(v3a_pkg::OP_RAY, 32'sh7fffffff, 32'sh10000, 0, 32'sh7fffffff, -32'sh10000,
			1, 32'sh7fffffff);
		push_word(v3a_pkg::OP_RAY, 0, 1, -1, 1, 1, 1, 32'sh00008000);
		push_word(4'd9, 1, 2, 3, 4, 5, 6, 7);
		push_word(4'd15, -1, -1, -1, -1, -1, -1, -1);
		push_random(70);
		wait_idle();

		settings[0] = '0;
		settings[1] = 17'd65536;
		settings[2] = MINLEN_W'($urandom_range(0, 65536));
		settings[3] = 17'd1;
		foreach (settings[p]) begin
			write_min_length(settings[p]);
			push_random(90);
			// receiver holds off a long stretch while words keep coming
			if (p == 1)
				hold_ask++;
			wait_idle();
		end

		if (mismatches == 0)
			$display("vector3_alu_test passed");
		else
			$display("vector3_alu_test failed");
		$finish;
	end

	// driver: new word at the falling edge, held until taken
	always @(negedge clk) begin
		vec_word_t w;
		if (arst_n && (!item_valid || took)) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (word_queue.size() != 0) begin
				w = word_queue.pop_front();
				opcode <= w.op;
				a_x <= w.a[0]; a_y <= w.a[1]; a_z <= w.a[2];
				b_x <= w.b[0]; b_y <= w.b[1]; b_z <= w.b[2];
				scale_value <= w.s;
				item_valid <= 1'b1;
				gap_left = pick_gap();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver ready, with random gaps and one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_ask) begin
				hold_seen = hold_ask;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (rgap_left > 0) begin
				rgap_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				rgap_left = pick_gap();
			end
		end
	end

	// predict on acceptance, check results, watch for stalls
	always @(posedge clk) begin
		vec_word_t w;
		vec_res_t  exp_r;
		logic      bad;
		took <= item_valid && item_ready;
		if (item_valid && item_ready) begin
			w.op = opcode;
			w.a[0] = a_x; w.a[1] = a_y; w.a[2] = a_z;
			w.b[0] = b_x; w.b[1] = b_y; w.b[2] = b_z;
			w.s = scale_value;
			result_queue.push_back(vector_result(w, min_len_q));
		end
		if (result_valid && result_ready) begin
			if (result_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: %h %h %h %h ovf=%b",
						r_x, r_y, r_z, r_scalar, overflow);
			end else begin
				exp_r = result_queue.pop_front();
				bad = (r_x !== exp_r.v[0]) || (r_y !== exp_r.v[1]) || (r_z !== exp_r.v[2])
					|| (r_scalar !== exp_r.sc) || (overflow !== exp_r.ovf);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: got %h %h %h %h ovf=%b, exp %h %h %h %h ovf=%b",
							r_x, r_y, r_z, r_scalar, overflow,
							exp_r.v[0], exp_r.v[1], exp_r.v[2], exp_r.sc, exp_r.ovf);
				end
			end
		end
		apb_wr = psel && penable && pwrite && pready;
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) || apb_wr)
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_MAX) begin
			$display("vector3_alu_test failed");
			$finish;
		end
	end

	initial begin
		took = 1'b0;
		gap_left = 0;
		rgap_left = 0;
		hold_left = 0;
		hold_seen = 0;
		quiet = 0;
	end

endmodule

### sim.f
hdl/v3a_pkg.sv
hdl/v3a_front.sv
hdl/v3a_iter.sv
hdl/v3a_back.sv
hdl/vector3_alu.sv
verif/vector3_alu_test.sv
